### rtl/core/accb_pkg.sv
`default_nettype none
package accb_pkg;

  // line length default and result sizes
  localparam int LINE_CHARS_DEF = 127;
  localparam int MAX_RESULTS    = 27;
  localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

  // stream word widths
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 112;
  localparam int IN_USER_W  = 2;
  localparam int OUT_USER_W = 4;

  typedef logic [7:0] char_t;

  // input kinds
  typedef enum logic [1:0] {
    MODE_HOST  = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_DISC  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // bus actions
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_RATE  = 3'd1,
    ACT_START = 3'd2,
    ACT_STOP  = 3'd3,
    ACT_TX    = 3'd4
  } action_t;

  // bitrate codes
  localparam logic [1:0] RATE_10K  = 2'd0;
  localparam logic [1:0] RATE_125K = 2'd1;
  localparam logic [1:0] RATE_500K = 2'd2;
  localparam logic [1:0] RATE_1M   = 2'd3;

  // characters of the text protocol
  localparam char_t CHR_NUL   = 8'h00;
  localparam char_t CHR_CR    = 8'h0D;
  localparam char_t CHR_ZERO  = 8'h30;
  localparam char_t CHR_ONE   = 8'h31;
  localparam char_t CHR_THREE = 8'h33;
  localparam char_t CHR_FOUR  = 8'h34;
  localparam char_t CHR_EIGHT = 8'h38;
  localparam char_t CHR_C     = 8'h43;
  localparam char_t CHR_O     = 8'h4F;
  localparam char_t CHR_S     = 8'h53;
  localparam char_t CHR_BIG_T = 8'h54;
  localparam char_t CHR_V     = 8'h56;
  localparam char_t CHR_SML_T = 8'h74;

  // hex digit value of a character, zero for anything else
  function automatic logic [3:0] hex_value(input char_t c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) v = c[3:0] + 4'd9;
    return v;
  endfunction

  // upper-case hex character of a nibble
  function automatic char_t hex_char(input logic [3:0] n);
    char_t c;
    if (n < 4'd10) c = CHR_ZERO + {4'd0, n};
    else c = 8'h37 + {4'd0, n};
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/core/ascii_can_command_bridge_unit.sv
// ascii can command bridge
// input channel (in_*): one word per host text byte, received bus frame or
// host disconnect, selected by in_tuser. host lines end at carriage return
// and are decoded when it arrives; received frames become t/T text while the
// bus is open.
// result channel (out_*): one word per reply character or bus action, with
// out_tlast on the final word caused by an input word.
// the first result word passes through the pending-text register and then
// the output register. an input word that causes n results puts n words on
// the result channel (one word per cycle from the output register while the
// receiver takes them, up to 27 for a received frame); an input word with no
// result loads no text, so such words can follow back to back.
// the next input word is taken while the last result of the previous one
// moves into the output register, so results follow each other with no gap.
// when the receiver stalls, the output register holds its word and the
// pending text waits; input is held off only while text is still pending.
// reset (rst_n low, synchronous) clears the line buffer, the bitrate and
// bus-open flags and drops any pending text.
`default_nettype none
module ascii_can_command_bridge_unit
  import accb_pkg::*;
#(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // host_byte[7:0], rx_id[36:8], rx_extended[37], rx_length[41:38],
  // rx_payload[105:42], zero[111:106]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // mode[1:0]
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // reply_byte[7:0], bitrate_code[9:8], tx_id[38:10], tx_extended[39],
  // tx_length[43:40], tx_payload[107:44], zero[111:108]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // reply_valid[0], action[3:1]
  output logic [OUT_USER_W-1:0]      out_tuser,
  output logic                       out_tlast
);

  localparam int POS_W = $clog2(LINE_CHARS + 1);

  // line state
  logic [POS_W-1:0] line_pos_r, line_pos_nxt;
  char_t            cmd_r, cmd_nxt;
  char_t            rate_chr_r, rate_chr_nxt;
  logic [31:0]      id_nib_r, id_nib_nxt;
  logic [3:0]       len_nib_r, len_nib_nxt;
  logic [63:0]      pay_nib_r, pay_nib_nxt;
  logic             drv_ready_r, drv_ready_nxt;
  logic             bus_open_r, bus_open_nxt;

  // pending text
  logic             job_valid_r, job_valid_nxt;
  logic [CNT_W-1:0] job_rem_r, job_rem_nxt;
  char_t            txt_r [MAX_RESULTS];
  char_t            txt_nxt [MAX_RESULTS];
  logic             job_rv_r;
  action_t          job_act_r;
  logic [1:0]       job_rate_r;
  logic [28:0]      job_id_r;
  logic             job_ext_r;
  logic [3:0]       job_len_r;
  logic [63:0]      job_pay_r;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;
  logic                  out_last_r;

  // decode of the incoming word
  logic             ld;
  logic [CNT_W-1:0] ld_cnt;
  char_t            ld_txt [MAX_RESULTS];
  logic             ld_rv;
  action_t          ld_act;
  logic [1:0]       ld_rate;
  logic [28:0]      ld_id;
  logic             ld_ext;
  logic [3:0]       ld_len;
  logic [63:0]      ld_pay;

  logic  out_adv, job_adv, in_acc;
  mode_t in_mode;
  char_t in_byte;
  logic [28:0] in_rx_id;
  logic        in_rx_ext;
  logic [3:0]  in_rx_len;
  logic [63:0] in_rx_pay;

  assign in_mode   = mode_t'(in_tuser[1:0]);
  assign in_byte   = in_tdata[7:0];
  assign in_rx_id  = in_tdata[36:8];
  assign in_rx_ext = in_tdata[37];
  assign in_rx_len = in_tdata[41:38];
  assign in_rx_pay = in_tdata[105:42];

  // handshake: input waits only while more than the moving word is pending
  assign out_adv   = !out_valid_r || out_tready;
  assign job_adv   = job_valid_r && out_adv;
  assign in_tready = !job_valid_r || (job_adv && (job_rem_r == CNT_W'(1)));
  assign in_acc    = in_tvalid && in_tready;

  // decode: state update and result text for one word
  always_comb begin
    logic [3:0]  hv;
    logic [3:0]  id_len;
    logic [3:0]  cap_len;
    logic [31:0] id32;
    logic [4:0]  end_pos;
    logic [28:0] std_id;
    line_pos_nxt  = line_pos_r;
    cmd_nxt       = cmd_r;
    rate_chr_nxt  = rate_chr_r;
    id_nib_nxt    = id_nib_r;
    len_nib_nxt   = len_nib_r;
    pay_nib_nxt   = pay_nib_r;
    drv_ready_nxt = drv_ready_r;
    bus_open_nxt  = bus_open_r;
    ld      = 1'b0;
    ld_cnt  = CNT_W'(1);
    ld_rv   = 1'b1;
    ld_act  = ACT_NONE;
    ld_rate = RATE_10K;
    ld_id   = '0;
    ld_ext  = 1'b0;
    ld_len  = 4'd0;
    ld_pay  = '0;
    for (int j = 0; j < MAX_RESULTS; j++) ld_txt[j] = CHR_CR;
    hv      = hex_value(in_byte);
    id_len  = (cmd_r == CHR_BIG_T) ? 4'd8 : 4'd3;
    cap_len = (in_rx_len > 4'd8) ? 4'd8 : in_rx_len;
    id32    = in_rx_ext ? {3'd0, in_rx_id} : {21'd0, in_rx_id[10:0]};
    end_pos = 5'd0;
    std_id  = {18'd0, id_nib_r[30:20]};

    unique case (in_mode)
      MODE_HOST: begin
        if (in_byte != CHR_CR) begin
          // store one character by position
          if (line_pos_r < POS_W'(LINE_CHARS)) begin
            if (line_pos_r == POS_W'(0)) cmd_nxt = in_byte;
            if (line_pos_r == POS_W'(1)) rate_chr_nxt = in_byte;
            for (int q = 1; q <= 8; q++) begin
              if (line_pos_r == POS_W'(q)) id_nib_nxt[4*(8-q) +: 4] = hv;
            end
            if (line_pos_r == POS_W'(id_len + 4'd1)) len_nib_nxt = hv;
            for (int k = 0; k < 16; k++) begin
              if (line_pos_r == POS_W'({4'd0, id_len} + 8'd2 + 8'(k)))
                pay_nib_nxt[4*(15-k) +: 4] = hv;
            end
            line_pos_nxt = line_pos_r + POS_W'(1);
          end
        end else begin
          // end of line: run the command
          unique case (cmd_r) inside
            CHR_S: begin
              ld            = 1'b1;
              ld_act        = ACT_RATE;
              drv_ready_nxt = 1'b1;
              unique case (rate_chr_r)
                CHR_ZERO:  ld_rate = RATE_10K;
                CHR_FOUR:  ld_rate = RATE_125K;
                CHR_EIGHT: ld_rate = RATE_1M;
                default:   ld_rate = RATE_500K;
              endcase
            end
            CHR_O: begin
              ld = 1'b1;
              if (drv_ready_r) begin
                bus_open_nxt = 1'b1;
                ld_act       = ACT_START;
              end
            end
            CHR_C: begin
              ld           = 1'b1;
              ld_act       = bus_open_r ? ACT_STOP : ACT_NONE;
              bus_open_nxt = 1'b0;
            end
            CHR_SML_T, CHR_BIG_T: begin
              if (bus_open_r) begin
                ld      = 1'b1;
                ld_act  = ACT_TX;
                ld_ext  = (cmd_r == CHR_BIG_T);
                ld_id   = ld_ext ? id_nib_r[28:0] : std_id;
                ld_len  = (len_nib_r > 4'd8) ? 4'd8 : len_nib_r;
                for (int b = 0; b < 8; b++) begin
                  ld_pay[63-8*b -: 8] = (4'(b) < ld_len) ? pay_nib_r[63-8*b -: 8] : 8'd0;
                end
              end
            end
            CHR_V: begin
              ld        = 1'b1;
              ld_cnt    = CNT_W'(6);
              ld_txt[0] = CHR_V;
              ld_txt[1] = CHR_ONE;
              ld_txt[2] = CHR_ZERO;
              ld_txt[3] = CHR_ONE;
              ld_txt[4] = CHR_THREE;
              ld_txt[5] = CHR_CR;
            end
            default: ld = 1'b0;
          endcase
          line_pos_nxt = '0;
          cmd_nxt      = CHR_NUL;
          rate_chr_nxt = CHR_NUL;
          id_nib_nxt   = '0;
          len_nib_nxt  = '0;
          pay_nib_nxt  = '0;
        end
      end
      MODE_FRAME: begin
        // received frame as t/T text
        if (bus_open_r) begin
          ld        = 1'b1;
          ld_txt[0] = in_rx_ext ? CHR_BIG_T : CHR_SML_T;
          if (in_rx_ext) begin
            for (int q = 0; q < 8; q++) ld_txt[1+q] = hex_char(id32[4*(7-q) +: 4]);
            ld_txt[9] = CHR_ZERO + {4'd0, cap_len};
            for (int m = 0; m < 16; m++) ld_txt[10+m] = hex_char(in_rx_pay[60-4*m +: 4]);
            end_pos = 5'd10 + {cap_len, 1'b0};
          end else begin
            for (int q = 0; q < 3; q++) ld_txt[1+q] = hex_char(id32[4*(2-q) +: 4]);
            ld_txt[4] = CHR_ZERO + {4'd0, cap_len};
            for (int m = 0; m < 16; m++) ld_txt[5+m] = hex_char(in_rx_pay[60-4*m +: 4]);
            end_pos = 5'd5 + {cap_len, 1'b0};
          end
          for (int j = 0; j < MAX_RESULTS; j++) begin
            if (end_pos == 5'(j)) ld_txt[j] = CHR_CR;
          end
          ld_cnt = CNT_W'(end_pos) + CNT_W'(1);
        end
      end
      MODE_DISC: begin
        // host gone: close the bus and drop the line
        if (bus_open_r) begin
          ld        = 1'b1;
          ld_rv     = 1'b0;
          ld_act    = ACT_STOP;
          ld_txt[0] = CHR_NUL;
        end
        bus_open_nxt = 1'b0;
        line_pos_nxt = '0;
        cmd_nxt      = CHR_NUL;
        rate_chr_nxt = CHR_NUL;
        id_nib_nxt   = '0;
        len_nib_nxt  = '0;
        pay_nib_nxt  = '0;
      end
      default: ld = 1'b0;
    endcase
  end

  // pending text: load on a new word, else shift one character out
  always_comb begin
    job_valid_nxt = job_valid_r;
    job_rem_nxt   = job_rem_r;
    for (int j = 0; j < MAX_RESULTS; j++) txt_nxt[j] = txt_r[j];
    if (in_acc && ld) begin
      job_valid_nxt = 1'b1;
      job_rem_nxt   = ld_cnt;
      for (int j = 0; j < MAX_RESULTS; j++) txt_nxt[j] = ld_txt[j];
    end else if (job_adv) begin
      job_valid_nxt = (job_rem_r != CNT_W'(1));
      job_rem_nxt   = job_rem_r - CNT_W'(1);
      for (int j = 0; j < MAX_RESULTS - 1; j++) txt_nxt[j] = txt_r[j+1];
      txt_nxt[MAX_RESULTS-1] = CHR_CR;
    end
  end

  // control and line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_pos_r  <= '0;
      cmd_r       <= CHR_NUL;
      rate_chr_r  <= CHR_NUL;
      id_nib_r    <= '0;
      len_nib_r   <= '0;
      pay_nib_r   <= '0;
      drv_ready_r <= 1'b0;
      bus_open_r  <= 1'b0;
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        line_pos_r  <= line_pos_nxt;
        cmd_r       <= cmd_nxt;
        rate_chr_r  <= rate_chr_nxt;
        id_nib_r    <= id_nib_nxt;
        len_nib_r   <= len_nib_nxt;
        pay_nib_r   <= pay_nib_nxt;
        drv_ready_r <= drv_ready_nxt;
        bus_open_r  <= bus_open_nxt;
      end
      job_valid_r <= job_valid_nxt;
      if (out_adv) out_valid_r <= job_valid_r;
    end
  end

  // pending text payload
  always_ff @(posedge clk) begin
    job_rem_r <= job_rem_nxt;
    for (int j = 0; j < MAX_RESULTS; j++) txt_r[j] <= txt_nxt[j];
    if (in_acc && ld) begin
      job_rv_r   <= ld_rv;
      job_act_r  <= ld_act;
      job_rate_r <= ld_rate;
      job_id_r   <= ld_id;
      job_ext_r  <= ld_ext;
      job_len_r  <= ld_len;
      job_pay_r  <= ld_pay;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (job_adv) begin
      out_data_r <= {4'd0, job_pay_r, job_len_r, job_ext_r, job_id_r, job_rate_r, txt_r[0]};
      out_user_r <= {job_act_r, job_rv_r};
      out_last_r <= (job_rem_r == CNT_W'(1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
